// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is held
`define SFBP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also runs through reset
`define SFBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sfbp_pkg.sv -----
package sfbp_pkg;

  // Record layout
  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = 5;
  localparam int KEY_W       = 2;
  localparam int KEY_IN_W    = 32;
  localparam int REC_WORDS_W = WORD_W * NUM_WORDS;
  localparam int REC_W       = REC_WORDS_W + KEY_W;

  // Stream packing
  localparam int IN_TDATA_W    = REC_WORDS_W + KEY_IN_W;
  localparam int IN_KEY_LSB    = REC_WORDS_W;
  localparam int OUT_TDATA_W   = ((REC_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - REC_W;
  localparam int OUT_LAYER_LSB = REC_WORDS_W;

  // Sizing
  localparam int CAPACITY_DEF = 64;
  localparam int CMDQ_DEPTH   = 2;
  localparam int OUTQ_DEPTH   = 4;
  localparam int OUTQ_PTR_W   = 2;
  localparam int OUTQ_CNT_W   = 3;

  // Key passes run from the top key down to the bottom key
  localparam logic [KEY_W-1:0] KEY_FIRST_PASS = 2'd3;
  localparam logic [KEY_W-1:0] KEY_LAST_PASS  = 2'd0;

  typedef struct packed {
    logic [KEY_W-1:0]                 key;
    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
  } rec_t;

  // Classified item handed from front to back
  typedef struct packed {
    rec_t rec;
    logic keep;
    logic last;
  } cmd_t;

  // Result waiting in the output queue
  typedef struct packed {
    rec_t rec;
    logic last;
    logic ovf;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } back_state_t;

endpackage

// ----- sv/sfbp_ram.sv -----
module sfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/sfbp_front.sv -----
module sfbp_front import sfbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  cmd_t          q_r [CMDQ_DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [KEY_IN_W-1:0] key_in;
  cmd_t          new_cmd;
  logic          push;

  // Classify the incoming record
  always_comb begin
    key_in            = in_tdata[IN_KEY_LSB +: KEY_IN_W];
    new_cmd.rec.words = in_tdata[REC_WORDS_W-1:0];
    new_cmd.rec.key   = key_in[KEY_W-1:0];
    new_cmd.keep      = (key_in[KEY_IN_W-1:KEY_W] == '0);
    new_cmd.last      = in_tlast;
  end

  assign in_tready = (cnt_r != 2'(CMDQ_DEPTH));
  // Drop records that neither store nor end the set
  assign push      = in_tvalid && in_tready && (new_cmd.keep || new_cmd.last);
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // Advance queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued records
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- sv/sfbp_back.sv -----
module sfbp_back import sfbp_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic [0:0]             out_tuser
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
  localparam logic [OUTQ_CNT_W-1:0] OQ_FULL = OUTQ_CNT_W'(OUTQ_DEPTH);

  back_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [KEY_W-1:0]     want_r, want_nxt;
  logic                 rdv_r, rdv_nxt;
  logic [KEY_W-1:0]     rd_want_r;
  rec_t                 pend_r;
  logic                 pend_v_r, pend_v_nxt;
  res_t                 oq_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [OUTQ_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [REC_W-1:0]     ram_rdata;
  rec_t                 rd_rec;
  logic                 match;
  logic                 credit;
  logic                 oq_push, oq_pop;
  res_t                 oq_wdata;
  res_t                 head;

  sfbp_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.rec),
    .re    (ram_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_rec = ram_rdata;
  assign match  = rdv_r && (rd_rec.key == rd_want_r);
  // Leave room for every read still in flight
  assign credit = (oq_cnt_r + OUTQ_CNT_W'(rdv_r)) < OQ_FULL;

  // Sequence store, scan and flush
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    want_nxt   = want_r;
    pend_v_nxt = pend_v_r;
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = count_r[ADDR_W-1:0];
    oq_push    = 1'b0;
    oq_wdata   = '{rec: pend_r, last: 1'b0, ovf: ovf_r};

    // Retire a matching read: release the previous pending record
    if (match) begin
      oq_push    = pend_v_r;
      pend_v_nxt = 1'b1;
    end

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.keep) begin
            if (count_r == CNT_CAP) begin
              ovf_nxt = 1'b1;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_ONE;
            end
          end
          if (cmd.last) begin
            if (count_nxt != '0) begin
              state_nxt = BK_SCAN;
              idx_nxt   = '0;
              want_nxt  = KEY_FIRST_PASS;
            end else begin
              ovf_nxt = 1'b0;
            end
          end
        end
      end
      BK_SCAN: begin
        if (credit) begin
          ram_re  = 1'b1;
          idx_nxt = idx_r + CNT_ONE;
          if (idx_r + CNT_ONE == count_r) begin
            idx_nxt = '0;
            if (want_r == KEY_LAST_PASS) begin
              state_nxt = BK_FLUSH;
            end else begin
              want_nxt = want_r - KEY_W'(1);
            end
          end
        end
      end
      BK_FLUSH: begin
        if (!rdv_r && (oq_cnt_r != OQ_FULL)) begin
          oq_push       = pend_v_r;
          oq_wdata.last = 1'b1;
          pend_v_nxt    = 1'b0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign rdv_nxt = ram_re;

  // Output queue
  assign head       = oq_r[oq_rp_r];
  assign out_tvalid = (oq_cnt_r != '0);
  assign oq_pop     = out_tvalid && out_tready;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, head.rec};
  assign out_tlast  = head.last;
  assign out_tuser  = head.ovf;
  assign oq_cnt_nxt = oq_cnt_r + OUTQ_CNT_W'(oq_push) - OUTQ_CNT_W'(oq_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      idx_r    <= '0;
      want_r   <= KEY_FIRST_PASS;
      rdv_r    <= 1'b0;
      pend_v_r <= 1'b0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      idx_r    <= idx_nxt;
      want_r   <= want_nxt;
      rdv_r    <= rdv_nxt;
      pend_v_r <= pend_v_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) begin
        oq_wp_r <= oq_wp_r + OUTQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + OUTQ_PTR_W'(1);
      end
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    rd_want_r <= want_r;
    if (match) begin
      pend_r <= rd_rec;
    end
    if (oq_push) begin
      oq_r[oq_wp_r] <= oq_wdata;
    end
  end

endmodule

// ----- sv/stable_four_bucket_partition.sv -----
// Stable four-bucket partition. Records (five 32-bit words plus a key) enter on
// the in_ stream, one transfer per cycle while the two-entry command queue has
// room; keys outside 0..3 are dropped, and records past CAPACITY are dropped
// and flag the set as overflowed (out_tuser). The transfer with in_tlast ends
// the set: the store is then read in four passes, key 3 down to key 0, each
// pass a read of every stored entry at one entry per cycle while the output
// queue has room, arrival order kept within each key, with out_tlast on the
// final result. An empty set emits nothing. Input transfers keep landing in
// the command queue during the emit until it fills.
module stable_four_bucket_partition import sfbp_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tile_word_0..tile_word_4, layer_key
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_word_0..out_word_4, out_layer, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // overflowed
  output logic [0:0]             out_tuser
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  sfbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sfbp_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- sv/sfbp_checker.sv -----
`include "assert_macros.svh"

module sfbp_checker import sfbp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic [0:0]             out_tuser
);

  logic             out_xfer;
  logic [KEY_W-1:0] out_layer;
  logic             run_open_r;
  logic [KEY_W-1:0] prev_layer_r;
  logic             run_ovf_r;

  assign out_xfer  = out_tvalid && out_tready;
  assign out_layer = out_tdata[OUT_LAYER_LSB +: KEY_W];

  // Track the result run in progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r <= 1'b0;
    end else if (out_xfer) begin
      run_open_r <= !out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_layer_r <= out_layer;
      run_ovf_r    <= out_tuser[0];
    end
  end

  `SFBP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")
  `SFBP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `SFBP_ASSERT(a_layer_desc, clk, rst_n, out_xfer && run_open_r |-> out_layer <= prev_layer_r, "layer rose within a run")
  `SFBP_ASSERT(a_ovf_const, clk, rst_n, out_xfer && run_open_r |-> out_tuser[0] == run_ovf_r, "overflow flag changed within a run")

endmodule

bind stable_four_bucket_partition sfbp_checker u_sfbp_checker (.*);

// ----- dv/stable_four_bucket_partition_test.sv -----
`timescale 1ns / 100ps

module stable_four_bucket_partition_test;
  import sfbp_pkg::*;

  localparam int STORE_CAP  = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = 4 * STORE_CAP + 40;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

  // One emitted record as the block should present it
  typedef struct packed {
    words_t           words;
    logic [KEY_W-1:0] layer;
    logic             last;
    logic             ovf;
  } sorted_rec_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // tile_word_0..tile_word_4, layer_key
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_word_0..out_word_4, out_layer, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  // overflowed
  logic [0:0]             out_tuser;

  // Model of the record store and the results it owes
  rec_t        held_recs[$];
  logic        held_ovf = 1'b0;
  sorted_rec_t sorted_queue[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int kept_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int set_count = 0;
  int ovf_set_count = 0;
  int idle_cycles = 0;

  stable_four_bucket_partition DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Throttle the result side
  always @(negedge clk) begin
    out_tready <= (($urandom % 100) >= recv_stall_pct);
  end

  // Store one record, and on the end of a set emit the buckets from key 3 down
  task automatic absorb_record(input words_t words, input logic [KEY_IN_W-1:0] key,
                               input logic last);
    rec_t        rec;
    sorted_rec_t res;
    int          first_idx;
    first_idx = sorted_queue.size();
    sent_count++;
    if (key <= 3) begin
      kept_count++;
      if (held_recs.size() >= STORE_CAP) begin
        held_ovf = 1'b1;
      end else begin
        rec.key   = key[KEY_W-1:0];
        rec.words = words;
        held_recs.insert(held_recs.size(), rec);
      end
    end
    if (last) begin
      set_count++;
      if (held_ovf) ovf_set_count++;
      for (int k = 3; k >= 0; k--) begin
        foreach (held_recs[i]) begin
          if (held_recs[i].key == k) begin
            res.words = held_recs[i].words;
            res.layer = KEY_W'(k);
            res.last  = 1'b0;
            res.ovf   = held_ovf;
            sorted_queue.insert(sorted_queue.size(), res);
          end
        end
      end
      if (sorted_queue.size() > first_idx) sorted_queue[sorted_queue.size()-1].last = 1'b1;
      held_recs.delete();
      held_ovf = 1'b0;
    end
  endtask

  // Offer one record; entered and left at a falling edge
  task automatic send_record(input words_t words, input logic [KEY_IN_W-1:0] key,
                             input logic last);
    while (($urandom % 100) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {key, words};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    absorb_record(words, key, last);
    @(negedge clk);
  endtask

  // Hold off the input until every owed result has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sorted_queue.size() != 0);
  endtask

  function automatic words_t rand_words();
    words_t w;
    for (int i = 0; i < NUM_WORDS; i++) w[i] = $urandom;
    return w;
  endfunction

  function automatic logic [KEY_IN_W-1:0] rand_key(input int bad_pct);
    logic [KEY_IN_W-1:0] k;
    if (($urandom % 100) < bad_pct) begin
      k = $urandom;
      if (k <= 3) k = k | (32'h1 << $urandom_range(2, 31));
    end else begin
      k = $urandom_range(0, 3);
    end
    return k;
  endfunction

  function automatic words_t fill_words(input logic [WORD_W-1:0] v);
    words_t w;
    for (int i = 0; i < NUM_WORDS; i++) w[i] = v;
    return w;
  endfunction

  // Payload extremes spread over every key
  task automatic test_field_extremes();
    send_record(fill_words(32'h8000_0000), 32'd0, 1'b0);
    send_record(fill_words(32'h7FFF_FFFF), 32'd3, 1'b0);
    send_record(fill_words(32'h0000_0000), 32'd1, 1'b0);
    send_record(fill_words(32'hFFFF_FFFF), 32'd2, 1'b0);
    send_record({32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1}, 32'd3, 1'b0);
    send_record(rand_words(), 32'd0, 1'b1);
  endtask

  // Out-of-range keys, negative ones too, and a dropped record closing the set
  task automatic test_dropped_keys();
    send_record(rand_words(), 32'd4, 1'b0);
    send_record(rand_words(), 32'd1, 1'b0);
    send_record(rand_words(), 32'hFFFF_FFFF, 1'b0);
    send_record(rand_words(), 32'h8000_0000, 1'b0);
    send_record(rand_words(), 32'h7FFF_FFFF, 1'b0);
    send_record(rand_words(), 32'd2, 1'b0);
    send_record(rand_words(), 32'd5, 1'b1);
  endtask

  // Empty sets interleaved with single-record sets
  task automatic test_empty_sets();
    send_record(rand_words(), 32'hFFFF_FFFF, 1'b1);
    send_record(rand_words(), 32'd3, 1'b1);
    send_record(rand_words(), 32'hFFFF_FFFC, 1'b1);
    send_record(rand_words(), 32'd0, 1'b1);
  endtask

  // Fill past capacity, then check that the flag clears on the next set
  task automatic test_store_overflow();
    for (int i = 0; i < STORE_CAP + 2; i++) send_record(rand_words(), rand_key(0), 1'b0);
    send_record(rand_words(), rand_key(0), 1'b1);
    send_record(rand_words(), rand_key(0), 1'b0);
    send_record(rand_words(), rand_key(0), 1'b1);
  endtask

  // Well-formed sets with random content, some empty or oversized
  task automatic test_random_sets(input int send_pct, input int recv_pct, input int goal);
    int start_sent;
    int set_len;
    int bad_pct;
    bit paused;
    start_sent = sent_count;
    paused = 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (sent_count - start_sent < goal) begin
      if ($urandom_range(0, 14) == 0) set_len = $urandom_range(STORE_CAP - 8, STORE_CAP + 4);
      else set_len = $urandom_range(1, 8);
      bad_pct = ($urandom_range(0, 19) == 0) ? 100 : 15;
      for (int i = 0; i < set_len; i++)
        send_record(rand_words(), rand_key(bad_pct), i == set_len - 1);
      if (!paused) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Compare each result transfer with the oldest owed record
  always @(posedge clk) begin
    sorted_rec_t exp_rec;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_queue.size() == 0) begin
        $error("result transfer with no record owed: tdata %h", out_tdata);
        error_count++;
      end else begin
        exp_rec = sorted_queue.pop_front();
        checked_count++;
        for (int i = 0; i < NUM_WORDS; i++) begin
          if (out_tdata[i*WORD_W +: WORD_W] !== exp_rec.words[i]) begin
            $error("out_word_%0d: expected %h, got %h", i, exp_rec.words[i],
                   out_tdata[i*WORD_W +: WORD_W]);
            error_count++;
          end
        end
        if (out_tdata[OUT_LAYER_LSB +: KEY_W] !== exp_rec.layer) begin
          $error("out_layer: expected %0d, got %0d", exp_rec.layer,
                 out_tdata[OUT_LAYER_LSB +: KEY_W]);
          error_count++;
        end
        if (out_tlast !== exp_rec.last) begin
          $error("run_last: expected %b, got %b", exp_rec.last, out_tlast);
          error_count++;
        end
        if (out_tuser[0] !== exp_rec.ovf) begin
          $error("overflowed: expected %b, got %b", exp_rec.ovf, out_tuser[0]);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d records owed", idle_cycles,
                 sorted_queue.size());
        $display("stable_four_bucket_partition_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 26;
    recv_stall_pct = 81;
    test_field_extremes();
    test_dropped_keys();
    test_empty_sets();
    test_store_overflow();

    test_random_sets(26, 81, 60);
    test_random_sets(81, 26, 60);
    test_random_sets(0, 0, 60);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("sent %0d records (%0d with keys 0..3) in %0d sets, %0d of them overflowed",
             sent_count, kept_count, set_count, ovf_set_count);
    $display("checked %0d sorted results under three throttle profiles", checked_count);
    if (error_count == 0 && sorted_queue.size() == 0) begin
      $display("stable_four_bucket_partition_test: PASS");
    end else begin
      $display("stable_four_bucket_partition_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sfbp_pkg.sv
sv/sfbp_ram.sv
sv/sfbp_front.sv
sv/sfbp_back.sv
sv/stable_four_bucket_partition.sv
sv/sfbp_checker.sv
dv/stable_four_bucket_partition_test.sv
